// File: rtl/swf_tag_scanner_macros.svh
// assertion macros for the scanner rtl
// expects clk and rst_n in the scope of the module that uses them
`ifndef SWF_TAG_SCANNER_MACROS_SVH
`define SWF_TAG_SCANNER_MACROS_SVH

// checked only while out of reset
`define SWF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// checked on every edge, reset included
`define SWF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: rtl/swf_pkg.sv
// types and constants for the swf tag scanner
// no dependencies
`default_nettype none

package swf_pkg;

    // input item: one file byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } swf_in_t;

    // result item: tag header or end-of-file summary
    typedef struct packed {
        logic        result_kind;
        logic [9:0]  tag_type;
        logic [31:0] tag_length;
        logic [31:0] tag_offset;
        logic        is_abc_tag;
        logic        has_abc;
        logic [2:0]  status;
        logic        last_result;
    } swf_res_t;

    // up to two results per byte go into the result queue at once
    typedef struct packed {
        logic [1:0] count;
        swf_res_t   first;
        swf_res_t   second;
    } swf_push_t;

    typedef enum logic [8:0] {
        PH_MAGIC      = 9'b0_0000_0001,
        PH_LENGTH     = 9'b0_0000_0010,
        PH_RECT_FIRST = 9'b0_0000_0100,
        PH_RECT_REST  = 9'b0_0000_1000,
        PH_FRAME      = 9'b0_0001_0000,
        PH_TAG_WAIT   = 9'b0_0010_0000,
        PH_TAG_HI     = 9'b0_0100_0000,
        PH_TAG_LONG   = 9'b0_1000_0000,
        PH_DONE       = 9'b1_0000_0000
    } swf_phase_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_MAGIC  = 3'd1,
        ST_COMPRESSED = 3'd2,
        ST_SIZE       = 3'd3,
        ST_TRUNC      = 3'd4,
        ST_WRAP       = 3'd5
    } swf_status_t;

    localparam logic KIND_TAG     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // magic bytes as read little-endian from bytes 0..2
    localparam logic [31:0] MAGIC_SWF = 32'h0053_5746;
    localparam logic [31:0] MAGIC_SWC = 32'h0053_5743;

    localparam logic [9:0]  TAG_ABC_A     = 10'd72;
    localparam logic [9:0]  TAG_ABC_B     = 10'd82;
    localparam logic [5:0]  LONG_LEN_MARK = 6'd63;
    localparam logic [31:0] POS_MAX       = 32'hFFFF_FFFF;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

endpackage

`default_nettype wire

// File: rtl/swf_parse_core.sv
// parse state and per-byte next-state logic of the swf tag scanner
// depends on swf_pkg
`default_nettype none

module swf_parse_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             take,
    input  wire swf_pkg::swf_in_t item,
    output swf_pkg::swf_push_t    push
);
    import swf_pkg::*;

    swf_phase_t  phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] decl_reg, decl_next;
    logic [31:0] acc_reg, acc_next;
    logic [1:0]  idx_reg, idx_next;
    logic [4:0]  rect_left_reg, rect_left_next;
    logic [31:0] tag_end_reg, tag_end_next;
    logic [9:0]  tag_type_reg, tag_type_next;
    logic        found_reg, found_next;
    swf_status_t err_reg, err_next;

    logic [32:0] pos_inc;
    logic [31:0] acc_byte;
    logic [31:0] decl_byte;
    logic [7:0]  rect_total;
    logic [4:0]  rect_left_first;
    logic        emit;
    logic [31:0] emit_len;
    logic [33:0] tag_end_sum;
    logic        emit_abc;
    swf_status_t sum_status;
    swf_res_t    tag_res;
    swf_res_t    sum_res;

    assign pos_inc   = {1'b0, pos_reg} + 33'd1;
    assign acc_byte  = acc_reg | (32'(item.data_byte) << {idx_reg, 3'b000});
    assign decl_byte = decl_reg | (32'(item.data_byte) << {idx_reg, 3'b000});
    // rectangle bytes = ceil((5 + 4n) / 8), n from the top five bits
    assign rect_total      = ({3'b000, item.data_byte[7:3]} << 2) + 8'd12;
    assign rect_left_first = rect_total[7:3] - 5'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        decl_next      = decl_reg;
        acc_next       = acc_reg;
        idx_next       = idx_reg;
        rect_left_next = rect_left_reg;
        tag_end_next   = tag_end_reg;
        tag_type_next  = tag_type_reg;
        found_next     = found_reg;
        err_next       = err_reg;
        emit           = 1'b0;
        emit_len       = '0;
        tag_end_sum    = '0;
        emit_abc       = 1'b0;
        sum_status     = ST_OK;
        tag_res        = '0;
        sum_res        = '0;
        push           = '0;

        if (take)
        begin
            unique case (phase_reg)
                PH_MAGIC:
                begin
                    if (pos_reg[31:2] == 30'd0 && pos_reg[1:0] != 2'd3)
                    begin
                        acc_next = acc_reg | (32'(item.data_byte) << {pos_reg[1:0], 3'b000});
                    end
                    if (pos_reg == 32'd2)
                    begin
                        if (acc_next == MAGIC_SWC)
                        begin
                            err_next   = ST_COMPRESSED;
                            phase_next = PH_DONE;
                        end
                        else if (acc_next != MAGIC_SWF)
                        begin
                            err_next   = ST_BAD_MAGIC;
                            phase_next = PH_DONE;
                        end
                    end
                    else if (pos_reg > 32'd2)
                    begin
                        phase_next = PH_LENGTH;
                        idx_next   = 2'd0;
                    end
                end
                PH_LENGTH:
                begin
                    decl_next = decl_byte;
                    if (idx_reg == 2'd3)
                    begin
                        idx_next   = 2'd0;
                        phase_next = PH_RECT_FIRST;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
                PH_RECT_FIRST:
                begin
                    rect_left_next = rect_left_first;
                    idx_next       = 2'd0;
                    phase_next     = (rect_left_first != 5'd0) ? PH_RECT_REST : PH_FRAME;
                end
                PH_RECT_REST:
                begin
                    rect_left_next = rect_left_reg - 5'd1;
                    if (rect_left_next == 5'd0)
                    begin
                        phase_next = PH_FRAME;
                    end
                end
                PH_FRAME:
                begin
                    if (idx_reg == 2'd3)
                    begin
                        idx_next     = 2'd0;
                        tag_end_next = pos_inc[31:0];
                        phase_next   = PH_TAG_WAIT;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
                PH_TAG_WAIT:
                begin
                    if (pos_reg >= tag_end_reg)
                    begin
                        if (pos_reg < decl_reg)
                        begin
                            acc_next   = 32'(item.data_byte);
                            phase_next = PH_TAG_HI;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_TAG_HI:
                begin
                    tag_type_next = {item.data_byte, acc_reg[7:6]};
                    if (acc_reg[5:0] == LONG_LEN_MARK)
                    begin
                        acc_next   = '0;
                        idx_next   = 2'd0;
                        phase_next = PH_TAG_LONG;
                    end
                    else
                    begin
                        emit     = 1'b1;
                        emit_len = 32'(acc_reg[5:0]);
                    end
                end
                PH_TAG_LONG:
                begin
                    acc_next = acc_byte;
                    if (idx_reg == 2'd3)
                    begin
                        idx_next = 2'd0;
                        emit     = 1'b1;
                        emit_len = acc_byte;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase

            // tag header complete: body starts after this byte
            if (emit)
            begin
                tag_end_sum = {1'b0, pos_inc} + {2'b00, emit_len};
                emit_abc    = (tag_type_next == TAG_ABC_A) || (tag_type_next == TAG_ABC_B);
                tag_res.result_kind = KIND_TAG;
                tag_res.tag_type    = tag_type_next;
                tag_res.tag_length  = emit_len;
                tag_res.tag_offset  = pos_inc[31:0];
                tag_res.is_abc_tag  = emit_abc;
                push.count = 2'd1;
                push.first = tag_res;
                if (emit_abc)
                begin
                    found_next = 1'b1;
                end
                if (tag_end_sum[33:32] != 2'd0)
                begin
                    if (err_next == ST_OK)
                    begin
                        err_next = ST_WRAP;
                    end
                    phase_next = PH_DONE;
                end
                else
                begin
                    tag_end_next = tag_end_sum[31:0];
                    phase_next   = PH_TAG_WAIT;
                end
            end

            if (item.last_byte)
            begin
                priority if (err_next == ST_BAD_MAGIC || err_next == ST_COMPRESSED ||
                             err_next == ST_SIZE)
                begin
                    sum_status = err_next;
                end
                else if (!(phase_next == PH_MAGIC || phase_next == PH_LENGTH) &&
                         pos_inc != {1'b0, decl_next})
                begin
                    sum_status = ST_SIZE;
                end
                else if (!(phase_next == PH_TAG_WAIT || phase_next == PH_DONE))
                begin
                    sum_status = ST_TRUNC;
                end
                else
                begin
                    sum_status = err_next;
                end
                sum_res.result_kind = KIND_SUMMARY;
                sum_res.has_abc     = (sum_status == ST_OK) && found_next;
                sum_res.status      = sum_status;
                sum_res.last_result = 1'b1;
                if (push.count == 2'd0)
                begin
                    push.first = sum_res;
                end
                else
                begin
                    push.second = sum_res;
                end
                push.count = push.count + 2'd1;

                // next byte opens a new file
                phase_next     = PH_MAGIC;
                pos_next       = '0;
                decl_next      = '0;
                acc_next       = '0;
                idx_next       = 2'd0;
                rect_left_next = 5'd0;
                tag_end_next   = '0;
                tag_type_next  = '0;
                found_next     = 1'b0;
                err_next       = ST_OK;
            end
            else
            begin
                if (pos_reg == POS_MAX)
                begin
                    if (err_next != ST_BAD_MAGIC && err_next != ST_COMPRESSED)
                    begin
                        err_next = ST_SIZE;
                    end
                    phase_next = PH_DONE;
                end
                pos_next = pos_inc[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_MAGIC;
            pos_reg       <= '0;
            decl_reg      <= '0;
            acc_reg       <= '0;
            idx_reg       <= 2'd0;
            rect_left_reg <= 5'd0;
            tag_end_reg   <= '0;
            tag_type_reg  <= '0;
            found_reg     <= 1'b0;
            err_reg       <= ST_OK;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            decl_reg      <= decl_next;
            acc_reg       <= acc_next;
            idx_reg       <= idx_next;
            rect_left_reg <= rect_left_next;
            tag_end_reg   <= tag_end_next;
            tag_type_reg  <= tag_type_next;
            found_reg     <= found_next;
            err_reg       <= err_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/swf_result_queue.sv
// result queue of the swf tag scanner, takes up to two results per cycle
// depends on swf_pkg and swf_tag_scanner_macros.svh
`default_nettype none
`include "swf_tag_scanner_macros.svh"

module swf_result_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire swf_pkg::swf_push_t push,
    output logic                    room,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output swf_pkg::swf_res_t       res_item
);
    import swf_pkg::*;

    swf_res_t             slots_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg, count_next;
    logic [FIFO_AW-1:0]   wr_second;
    logic [FIFO_CW-1:0]   free_slots;
    logic                 pop;

    assign pop         = res_valid && !res_stall;
    assign wr_second   = wr_ptr_reg + FIFO_AW'(1);
    assign wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.count);
    assign rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
    assign count_next  = count_reg + FIFO_CW'(push.count) - FIFO_CW'(pop);
    assign free_slots  = FIFO_CW'(FIFO_DEPTH) - count_reg;
    // room for two results regardless of the read side
    assign room        = count_reg <= FIFO_CW'(FIFO_DEPTH - 2);
    assign res_valid   = count_reg != '0;
    assign res_item    = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            slots_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            slots_reg[wr_second] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `SWF_ASSERT(a_no_overflow, FIFO_CW'(push.count) <= free_slots, "result queue overflow")
    `SWF_ASSERT(a_push_two_max, push.count != 2'd3, "more than two results pushed")
    `SWF_ASSERT(a_pop_count,
                (pop && push.count == 2'd0) |=> count_reg == $past(count_reg) - FIFO_CW'(1),
                "queue count lost a pop")
    `SWF_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !res_valid, "result valid after reset")

endmodule

`default_nettype wire

// File: rtl/swf_tag_scanner.sv
// top level of the swf tag scanner: input register, parse core, result queue
// depends on swf_pkg, swf_parse_core and swf_result_queue
`default_nettype none

// channel   dir  handshake               payload
// byte      in   byte_valid / byte_stall  byte_item (data_byte, last_byte)
// res       out  res_valid / res_stall    res_item (tag header or summary)
//
// one byte per cycle sustained while the receiver keeps up
// the parser takes a byte from the input register after its handshake, and its
// results are written into the result queue and offered from there, so the
// input register and the queue lie between a byte handshake and its results
// a byte marked last can give two results (tag, then summary) in one cycle
// async reset starts a new file at position zero; the byte after a summary
// also starts a new file
// byte_stall rises only when the four-deep result queue has under two free slots

module swf_tag_scanner (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             byte_valid,
    output logic                  byte_stall,
    input  wire swf_pkg::swf_in_t byte_item,
    output logic                  res_valid,
    input  wire logic             res_stall,
    output swf_pkg::swf_res_t     res_item
);
    import swf_pkg::*;

    // input register: holds one byte until the parser takes it
    logic      in_full_reg, in_full_next;
    swf_in_t   in_item_reg;
    logic      accept;
    logic      take;
    logic      room;
    swf_push_t push;

    // parser moves on when the queue can absorb a worst-case two results
    assign take       = in_full_reg && room;
    assign byte_stall = in_full_reg && !room;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (accept)
        begin
            in_full_next = 1'b1;
        end
        else if (take)
        begin
            in_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= byte_item;
        end
    end

    // per-byte parse: magic, length, rectangle, frame fields, tag walk
    swf_parse_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (in_item_reg),
        .push  (push)
    );

    // results wait here until the receiver takes them
    swf_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule

`default_nettype wire
